// File: design/fpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types, defaults and the fast-packet group list for the reassembler.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int SOURCES_DEF     = 256;
  localparam int MAX_PAYLOAD_DEF = 223;
  localparam int NUM_FAST        = 29;

  localparam logic [17:0] FAST_PGNS [NUM_FAST] = '{
    18'd127489, 18'd126464, 18'd126208, 18'd129795, 18'd129794, 18'd129797,
    18'd129029, 18'd129285, 18'd127237, 18'd129540, 18'd129796, 18'd129284,
    18'd127497, 18'd127496, 18'd127498, 18'd129039, 18'd127503, 18'd129038,
    18'd129041, 18'd129809, 18'd130320, 18'd129040, 18'd128275, 18'd130578,
    18'd129810, 18'd129045, 18'd129044, 18'd126996, 18'd126998
  };

  // one queued CAN frame
  typedef struct packed {
    logic             is_fast;
    logic [28:0]      frame_id;
    logic [3:0]       data_count;
    logic [7:0][7:0]  bytes;
  } item_t;

  // PDU1 groups (PF below 240) carry a destination in PS, so it is masked
  function automatic logic pgn_is_fast(logic [28:0] id);
    logic [17:0] pgn;
    logic        hit;
    pgn = id[25:8];
    hit = 1'b0;
    if (id[23:16] < 8'd240) pgn[7:0] = 8'h00;
    for (int i = 0; i < NUM_FAST; i++) begin
      if (FAST_PGNS[i] == pgn) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// File: design/fpr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: design/fpr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_front
// Accepts frames, tags fast-packet groups and holds them in a two-word queue.
// ----------------------------------------------------------------------------
module fpr_front import fpr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [28:0]  in_frame_id,
  input  wire logic [3:0]   in_data_count,
  input  wire logic [63:0]  in_bytes,
  output logic              q_valid,
  output item_t             q_item,
  input  wire logic         q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      new_item;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    new_item.is_fast    = pgn_is_fast(in_frame_id);
    new_item.frame_id   = in_frame_id;
    new_item.data_count = in_data_count;
    new_item.bytes      = in_bytes;
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= new_item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/fpr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_back
// Per-source reassembly state, eight byte-lane buffers and the output word.
// ----------------------------------------------------------------------------
module fpr_back import fpr_pkg::*; #(
  parameter int SOURCES     = SOURCES_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [28:0]        out_id,
  output logic [7:0]         out_length,
  output logic               out_last,
  output logic [7:0][7:0]    out_payload
);

  localparam int SW     = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int ROWS   = (MAX_PAYLOAD + 7) / 8;
  localparam int RW     = $clog2(ROWS);
  localparam int LDEPTH = (SOURCES > 1) ? SOURCES * (2 ** RW) : 2 ** (RW + 1);
  localparam logic [7:0] MAXP = 8'(MAX_PAYLOAD);

  typedef logic [SW-1:0] src_idx_t;
  typedef src_idx_t src_tab_t [256];

  typedef struct packed {
    logic [2:0]  grp;
    logic [28:0] id;
    logic [7:0]  cnt;
    logic [7:0]  len;
  } meta_t;

  localparam int MW = $bits(meta_t);

  function automatic src_tab_t build_src_tab();
    src_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = SW'(i % SOURCES);
    return t;
  endfunction

  localparam src_tab_t SRC_TAB = build_src_tab();

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_RD, ST_LOAD} state_t;

  state_t         state;
  item_t          cur;
  src_idx_t       cur_src;
  logic [28:0]    msg_id;
  logic [7:0]     msg_len;
  logic [RW-1:0]  beat;
  logic [RW-1:0]  last_beat;
  logic [SOURCES-1:0] tag_valid;

  logic           out_free;
  logic           out_load;
  logic           meta_rd_en;
  meta_t          meta_rd;
  meta_t          new_meta;
  src_idx_t       in_src;

  logic [2:0]     grp;
  logic [4:0]     seq;
  logic           seq0;
  logic           match;
  logic           keep;
  logic           complete;
  logic [7:0]     len_c;
  logic [8:0]     cnt_sum;
  logic [8:0]     base;
  logic [2:0]     first_b;
  logic [2:0]     nbytes;

  logic [7:0]             lane_we;
  logic [7:0][SW+RW-1:0]  lane_waddr;
  logic [7:0][7:0]        lane_wdata;
  logic [7:0][7:0]        lane_rdata;
  logic [SW+RW-1:0]       lane_raddr;
  logic [7:0][7:0]        beat_bytes;

  assign out_free = !out_valid || out_ready;
  assign in_src   = SRC_TAB[q_item.frame_id[7:0]];
  assign q_pop    = (state == ST_IDLE) && q_valid && (q_item.is_fast || out_free);
  assign meta_rd_en = q_pop && q_item.is_fast;
  // a new word is loaded into the output register this cycle
  assign out_load = (q_pop && !q_item.is_fast) || ((state == ST_LOAD) && out_free);

  fpr_ram #(.WIDTH(MW), .DEPTH(SOURCES)) u_meta (
    .clk     (clk),
    .wr_en   (state == ST_LOOK),
    .wr_addr (cur_src),
    .wr_data (new_meta),
    .rd_en   (meta_rd_en),
    .rd_addr (in_src),
    .rd_data (meta_rd)
  );

  always_comb begin
    grp     = cur.bytes[0][7:5];
    seq     = cur.bytes[0][4:0];
    seq0    = (seq == 5'd0);
    match   = tag_valid[cur_src] && (meta_rd.grp == grp) && (meta_rd.id == cur.frame_id);
    len_c   = (cur.bytes[1] > MAXP) ? MAXP : cur.bytes[1];
    cnt_sum = {1'b0, meta_rd.cnt} + 9'd7;
    if (seq0) begin
      new_meta = '{grp: grp, id: cur.frame_id, cnt: 8'd6, len: len_c};
    end else begin
      new_meta     = meta_rd;
      new_meta.cnt = cnt_sum[8] ? 8'hff : cnt_sum[7:0];
    end
    keep     = seq0 || match;
    complete = keep && (new_meta.cnt >= new_meta.len);
    // later fragments land at 7*seq - 1
    base    = seq0 ? 9'd0 : ({1'b0, seq, 3'b000} - {4'b0000, seq} - 9'd1);
    first_b = seq0 ? 3'd2 : 3'd1;
    nbytes  = seq0 ? 3'd6 : 3'd7;
  end

  // each of up to seven consecutive bytes falls in its own lane
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      logic [2:0] k;
      logic [8:0] off;
      k             = 3'(j) - base[2:0];
      off           = base + {6'd0, k};
      lane_we[j]    = (state == ST_LOOK) && keep && (k < nbytes) && (off < {1'b0, MAXP});
      lane_waddr[j] = {cur_src, off[3 +: RW]};
      lane_wdata[j] = cur.bytes[3'(first_b + k)];
    end
  end

  assign lane_raddr = {cur_src, beat};

  for (genvar g = 0; g < 8; g++) begin : g_lane
    fpr_ram #(.WIDTH(8), .DEPTH(LDEPTH)) u_lane (
      .clk     (clk),
      .wr_en   (lane_we[g]),
      .wr_addr (lane_waddr[g]),
      .wr_data (lane_wdata[g]),
      .rd_en   (state == ST_RD),
      .rd_addr (lane_raddr),
      .rd_data (lane_rdata[g])
    );
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      logic [8:0] off;
      off = {1'b0, 5'(beat), 3'(j)};
      beat_bytes[j] = (off < {1'b0, msg_len}) ? lane_rdata[j] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tag_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.is_fast) begin
              cur     <= q_item;
              cur_src <= in_src;
              state   <= ST_LOOK;
            end else begin
              out_valid  <= 1'b1;
              out_kind   <= 1'b0;
              out_id     <= q_item.frame_id;
              out_last   <= 1'b1;
              out_length <= (q_item.data_count > 4'd8) ? 8'd8 : {4'd0, q_item.data_count};
              for (int j = 0; j < 8; j++) begin
                out_payload[j] <= (4'(j) < q_item.data_count) ? q_item.bytes[j] : 8'h00;
              end
            end
          end
        end
        ST_LOOK: begin
          tag_valid[cur_src] <= keep && !complete;
          msg_id    <= new_meta.id;
          msg_len   <= new_meta.len;
          beat      <= '0;
          last_beat <= (new_meta.len == 8'd0) ? '0 : RW'((new_meta.len - 8'd1) >> 3);
          state     <= complete ? ST_RD : ST_IDLE;
        end
        ST_RD: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_kind    <= 1'b1;
            out_id      <= msg_id;
            out_length  <= msg_len;
            out_last    <= (beat == last_beat);
            out_payload <= beat_bytes;
            if (beat == last_beat) begin
              state <= ST_IDLE;
            end else begin
              beat  <= beat + 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/fast_packet_reassembler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fast_packet_reassembler
// NMEA 2000 fast-packet reassembly of a stream of extended CAN frames.
// ----------------------------------------------------------------------------
// Usage: one CAN frame per s_axis word. Frames whose group is not a fast-packet
// group leave as a single m_axis word (tuser 0). Fragments of fast-packet
// groups are gathered per source address; when a message is complete its
// payload leaves as 8-byte words (tuser 1), tlast on the final one, at most
// ceil(MAX_PAYLOAD/8) words.
// Flow: a pass-through frame goes from the queue straight into the registered
// output word; a completing fragment passes the queue, the state lookup and
// the buffer read before its first word, and each further word needs another
// registered read of the byte-lane buffers. Other fragments only update state.
// A two-word queue sits in front, so frames are taken while a message drains.
// Reset clears the queue, the output valid and every source's open message;
// no clearing pass is needed. When the receiver stalls the output word holds,
// the back end waits, and s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module fast_packet_reassembler import fpr_pkg::*; #(
  parameter int SOURCES     = SOURCES_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // frame_id, data_count, in_byte_0 .. in_byte_7, zero pad
  input  wire logic [103:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // message_id, message_length, payload_byte_0 .. payload_byte_7, zero pad
  output logic [103:0]       m_tdata,
  output logic               m_tlast,
  // message_kind
  output logic               m_tuser
);

  logic            q_valid;
  item_t           q_item;
  logic            q_pop;
  logic [28:0]     out_id;
  logic [7:0]      out_length;
  logic [7:0][7:0] out_payload;

  fpr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_frame_id   (s_tdata[28:0]),
    .in_data_count (s_tdata[32:29]),
    .in_bytes      (s_tdata[96:33]),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  fpr_back #(.SOURCES(SOURCES), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser),
    .out_id      (out_id),
    .out_length  (out_length),
    .out_last    (m_tlast),
    .out_payload (out_payload)
  );

  assign m_tdata = {3'b000, out_payload, out_length, out_id};

endmodule
`default_nettype wire

// File: bench/fast_packet_reassembler_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fast_packet_reassembler_test
// Self-checking bench for the fast-packet reassembler. A local predictor keeps
// per-source message state, works out the words expected for each accepted
// frame and checks every output word against them in order. Directed frames
// cover pass-through, short, zero-length, clamped, overflowing and broken
// messages. Random traffic is mostly well-formed fast-packet sequences with
// random content, with noise frames and broken sequences mixed in.
// ----------------------------------------------------------------------------
module fast_packet_reassembler_test;
  import fpr_pkg::*;

  localparam int NSRC   = 256;
  localparam int MAXPAY = 223;
  localparam logic [7:0] NO_GROUP = 8'hff;

  typedef struct packed {
    logic        kind;
    logic [28:0] id;
    logic [7:0]  len;
    logic        last;
    logic [63:0] bytes;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  fast_packet_reassembler u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial forever #5 clk = ~clk;

  // predictor state per source
  logic [7:0]  grp_open [NSRC];
  logic [28:0] grp_id   [NSRC];
  logic [7:0]  gathered [NSRC];
  logic [7:0]  want_len [NSRC];
  logic [7:0]  payload  [NSRC][MAXPAY];

  word_t expected_words[$];
  int mismatches = 0;
  int words_seen = 0;
  int frames_sent = 0;
  bit idle_send = 1'b0;
  bit idle_recv = 1'b0;
  bit hold_off  = 1'b0;

  function automatic bit fast_group(logic [28:0] id);
    logic [17:0] pgn;
    bit hit;
    pgn = id[25:8];
    hit = 1'b0;
    if (id[23:16] < 8'd240) pgn[7:0] = 8'h00;
    foreach (FAST_PGNS[i]) if (FAST_PGNS[i] == pgn) hit = 1'b1;
    return hit;
  endfunction

  task automatic predict_frame(logic [28:0] id, logic [3:0] dlc, logic [7:0] d [8]);
    word_t w;
    int src, seq, base, n, cnt, beats;
    logic [7:0] grp;
    if (!fast_group(id)) begin
      n = (dlc > 8) ? 8 : dlc;
      w = '0;
      w.id = id; w.len = 8'(n); w.last = 1'b1;
      for (int k = 0; k < 8; k++) if (k < n) w.bytes[8*k +: 8] = d[k];
      expected_words.push_back(w);
      return;
    end
    src = id[7:0];
    grp = {5'd0, d[0][7:5]};
    seq = d[0][4:0];
    if (grp != grp_open[src] || grp_id[src] != id) grp_open[src] = NO_GROUP;
    if (seq == 0) begin
      grp_id[src] = id; grp_open[src] = grp; gathered[src] = 8'd6;
      want_len[src] = (d[1] > MAXPAY) ? 8'(MAXPAY) : d[1];
      for (int k = 0; k < 6; k++) payload[src][k] = d[2+k];
    end else begin
      if (grp_open[src] == NO_GROUP) return;
      base = 6 + 7*(seq-1);
      for (int k = 0; k < 7; k++) if (base+k < MAXPAY) payload[src][base+k] = d[1+k];
      cnt = gathered[src] + 7;
      gathered[src] = 8'((cnt > 255) ? 255 : cnt);
    end
    if (gathered[src] >= want_len[src]) begin
      grp_open[src] = NO_GROUP;
      beats = (want_len[src] + 7) / 8;
      if (beats == 0) beats = 1;
      for (int b = 0; b < beats; b++) begin
        w = '0;
        w.kind = 1'b1; w.id = grp_id[src]; w.len = want_len[src];
        w.last = (b == beats-1);
        for (int j = 0; j < 8; j++)
          if (b*8+j < want_len[src]) w.bytes[8*j +: 8] = payload[src][b*8+j];
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic send_frame(logic [28:0] id, logic [3:0] dlc, logic [7:0] d [8]);
    logic [103:0] w;
    int gap;
    if (idle_send && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w = '0;
    w[28:0] = id; w[32:29] = dlc;
    for (int k = 0; k < 8; k++) w[33+8*k +: 8] = d[k];
    s_tdata <= w;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_frame(id, dlc, d);
    frames_sent++;
  endtask

  task automatic release_sender();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver side: random stalls plus an optional long hold
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end else if (idle_recv && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // output checker
  always @(posedge clk) begin
    word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser; got.id = m_tdata[28:0]; got.len = m_tdata[36:29];
      got.last = m_tlast; got.bytes = m_tdata[100:37];
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: kind %0d/%0d id %h/%h len %0d/%0d last %0d/%0d data %h/%h",
                     want.kind, got.kind, want.id, got.id, want.len, got.len,
                     want.last, got.last, want.bytes, got.bytes);
        end
      end
    end
  end

  function automatic logic [28:0] fast_id(int pgn_sel, logic [7:0] src);
    logic [17:0] pgn;
    pgn = FAST_PGNS[pgn_sel];
    return {3'($urandom_range(0, 7)), pgn, src};
  endfunction

  // one fast-packet message; broken adds a random fault
  task automatic send_message(logic [28:0] id, logic [2:0] grp, int len, bit broken);
    logic [7:0] d [8];
    int nfr;
    nfr = (len <= 6) ? 1 : 1 + (len - 6 + 6) / 7;
    for (int f = 0; f < nfr; f++) begin
      foreach (d[k]) d[k] = 8'($urandom);
      d[0] = {grp, 5'(f)};
      if (f == 0) d[1] = 8'(len);
      if (broken && f > 0 && $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1)) d[0][7:5] = grp + 3'd1;
        else d[0][4:0] = 5'($urandom);
      end
      send_frame(id, 4'd8, d);
      if (broken && $urandom_range(0, 4) == 0) break;
    end
  endtask

  task automatic test_directed();
    logic [7:0] d [8];
    logic [28:0] id;
    // pass-through: dlc 0, 8, 15, all bits high and low
    foreach (d[k]) d[k] = 8'hff;
    send_frame(29'h1fffffff, 4'd15, d);
    send_frame(29'h1fffffff, 4'd8, d);
    foreach (d[k]) d[k] = 8'h00;
    send_frame(29'h00000000, 4'd0, d);
    foreach (d[k]) d[k] = 8'(8'h5a + k);
    send_frame(29'h0cf00400, 4'd3, d);
    // zero length and short message
    id = fast_id(0, 8'h01);
    d[0] = 8'h20; d[1] = 8'd0; send_frame(id, 4'd8, d);
    d[0] = 8'h40; d[1] = 8'd6; send_frame(id, 4'd8, d);
    // later fragment with nothing open is ignored
    d[0] = 8'h41; send_frame(id, 4'd8, d);
    // length 255 clamped to MAXPAY, fragment 20 sent last to complete it
    id = fast_id(27, 8'hff);
    foreach (d[k]) d[k] = 8'hff;
    d[0] = 8'he0; d[1] = 8'hff; send_frame(id, 4'd8, d);
    for (int s = 1; s < 31; s++) begin
      if (s == 20) continue;
      foreach (d[k]) d[k] = 8'($urandom);
      d[0] = {3'd7, 5'(s)};
      send_frame(id, 4'd8, d);
    end
    d[0] = {3'd7, 5'd31}; send_frame(id, 4'd8, d);
    d[0] = {3'd7, 5'd20}; send_frame(id, 4'd8, d);
    // group and id mismatch, then a restart
    id = fast_id(3, 8'h00);
    send_message(id, 3'd0, 20, 1'b0);
    d[0] = 8'h00; d[1] = 8'd20; send_frame(id, 4'd8, d);
    d[0] = 8'h21; send_frame(id, 4'd8, d);
    d[0] = 8'h01; send_frame(id ^ 29'h10000000, 4'd8, d);
    send_message(id, 3'd0, 13, 1'b0);
    // fill the whole buffer of each random source, so broken sequences
    // with gaps only ever read bytes that have been stored
    for (int s = 0; s < 4; s++) send_message(fast_id(0, 8'(s)), 3'd0, MAXPAY, 1'b0);
  endtask

  task automatic test_random(int n, bit stall);
    logic [7:0] d [8];
    logic [28:0] id;
    int start;
    idle_send = stall; idle_recv = stall;
    start = frames_sent;
    while (frames_sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          foreach (d[k]) d[k] = 8'($urandom);
          send_frame(29'($urandom), 4'($urandom), d);
        end
        2: send_message(fast_id($urandom_range(0, NUM_FAST-1), 8'($urandom_range(0, 3))),
                        3'($urandom), $urandom_range(0, 255), 1'b1);
        default: begin
          id = fast_id($urandom_range(0, NUM_FAST-1), 8'($urandom_range(0, 3)));
          send_message(id, 3'($urandom), ($urandom_range(0, 5) == 0) ?
                       $urandom_range(100, 255) : $urandom_range(0, 40), 1'b0);
        end
      endcase
    end
    release_sender();
  endtask

  task automatic test_back_pressure();
    int waited;
    hold_off = 1'b1;
    fork
      test_random(20, 1'b0);
      begin
        waited = 0;
        while (waited < 400) begin
          @(posedge clk);
          waited++;
        end
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (expected_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int s = 0; s < NSRC; s++) begin
      grp_open[s] = NO_GROUP; grp_id[s] = '0; gathered[s] = 8'd0; want_len[s] = 8'd0;
      for (int k = 0; k < MAXPAY; k++) payload[s][k] = 8'h00;
    end
    @(posedge clk);
    test_directed();
    release_sender();
    test_back_pressure();
    test_random(160, 1'b1);
    test_random(60, 1'b0);
    drain();
    $display("Ran %0d frames, checked %0d output words (%0d mismatches)",
             frames_sent, words_seen, mismatches);
    $display("Covered pass-through, short, clamped, broken and stalled traffic");
    if (mismatches == 0 && expected_words.size() == 0)
      $display("Testbench completed without errors");
    else begin
      if (expected_words.size() != 0)
        $display("%0d expected words never arrived", expected_words.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
design/fpr_pkg.sv
design/fpr_ram.sv
design/fpr_front.sv
design/fpr_back.sv
design/fast_packet_reassembler.sv
bench/fast_packet_reassembler_test.sv
